[rtl/bounded_stack_push_pop_peek_defines.svh]
// Assertion macros shared by the stack RTL.
`ifndef BOUNDED_STACK_PUSH_POP_PEEK_DEFINES_SVH
`define BOUNDED_STACK_PUSH_POP_PEEK_DEFINES_SVH

`ifndef SYNTHESIS
`define BSPP_ASSERT(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("stack assertion failed");
`define BSPP_ASSERT_RST(label, clk_sig, prop) \
  label: assert property (@(posedge clk_sig) prop) \
    else $error("stack reset assertion failed");
`else
`define BSPP_ASSERT(label, clk_sig, rst_sig, prop)
`define BSPP_ASSERT_RST(label, clk_sig, prop)
`endif

`endif

[rtl/bspp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bspp_pkg;

  localparam int DEPTH   = 256;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 9;
  localparam int POS_W   = 9;
  localparam int OCNT_W  = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_t;

endpackage

`default_nettype wire

[rtl/bounded_stack_push_pop_peek.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_stack_push_pop_peek_defines.svh"

// Bounded LIFO stack of signed 32-bit words in a single-port-style synchronous
// memory (one write or one read per request). A request is taken on any cycle
// with start high; busy never rises, so one request per cycle is sustained.
// Each request returns exactly one result in the next cycle, marked by done for a
// single cycle; the receiver cannot stall it, so capture it when done is high.
// The entry count is updated at the request edge, and the memory read issued in
// that same edge supplies read_value. The capacity register (reset 256, clipped
// to the memory depth) may be written with cfg_we/cfg_data only while no result
// is pending.
module bounded_stack_push_pop_peek
  import bspp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               mode,
  input  wire logic signed [DATA_W-1:0] push_value,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic                     cfg_we,
  input  wire logic [CAP_W-1:0]         cfg_data,
  output logic                          done,
  output logic signed [DATA_W-1:0]      read_value,
  output logic [1:0]                    status,
  output logic                          is_empty,
  output logic                          is_full,
  output logic [OCNT_W-1:0]             entry_count
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  cap_eff;
  logic              full_now;
  logic              empty_now;

  logic [ADDR_W-1:0] addr;
  logic              wr_en;
  logic              rd_en;
  status_t           st_next;

  logic              rd_sel;
  status_t           status_q;
  logic              empty_q;
  logic              full_q;

  assign busy = 1'b0;

  always_comb begin
    if (32'(capacity) > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign full_now  = (count >= cap_eff);
  assign empty_now = (count == '0);

  always_comb begin
    count_next = count;
    addr       = count[ADDR_W-1:0];
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    st_next    = ST_OK;
    unique case (mode_t'(mode))
      MODE_PUSH: begin
        if (full_now) begin
          st_next = ST_OVERFLOW;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_POP: begin
        if (empty_now) begin
          st_next = ST_UNDERFLOW;
        end else begin
          count_next = count - CNT_W'(1);
          addr       = count_next[ADDR_W-1:0];
          rd_en      = 1'b1;
        end
      end
      MODE_PEEK: begin
        if (position == '0 || 32'(position) > 32'(count)) begin
          st_next = ST_BAD_POS;
        end else begin
          addr  = ADDR_W'(count - CNT_W'(position));
          rd_en = 1'b1;
        end
      end
      MODE_QUERY: begin
        st_next = ST_OK;
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  // Memory: write on push, registered read on pop or peek.
  always_ff @(posedge clk) begin
    if (start && wr_en) begin
      mem[addr] <= push_value;
    end
    if (start && rd_en) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      done <= start;
      if (start) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_sel   <= rd_en;
      status_q <= st_next;
      empty_q  <= (count_next == '0);
      full_q   <= (count_next >= cap_eff);
    end
  end

  assign read_value  = rd_sel ? $signed(mem_q) : '0;
  assign status      = status_q;
  assign is_empty    = empty_q;
  assign is_full     = full_q;
  assign entry_count = OCNT_W'(count);

  `BSPP_ASSERT(a_one_result, clk, rst, start |=> done)
  `BSPP_ASSERT(a_no_spurious, clk, rst, !start |=> !done)
  `BSPP_ASSERT(a_push_grows, clk, rst,
    (start && mode == MODE_PUSH && !full_now) |=> (count == $past(count) + CNT_W'(1)))
  `BSPP_ASSERT(a_empty_flag, clk, rst, done |-> (is_empty == (entry_count == '0)))
  `BSPP_ASSERT(a_underflow_empty, clk, rst, (done && status == ST_UNDERFLOW) |-> is_empty)
  `BSPP_ASSERT_RST(a_reset_idle, clk, rst |=> (!done && count == '0))

endmodule

`default_nettype wire

[test/bounded_stack_push_pop_peek_tb.sv]
`timescale 1ns / 1ps

module bounded_stack_push_pop_peek_tb;
  import bspp_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    status_t                  status;
    logic                     is_empty;
    logic                     is_full;
    logic [OCNT_W-1:0]        entry_count;
  } stack_result_t;

  // Mirror of the stack contents and count; predicts one result per request.
  class stack_mirror;
    logic signed [DATA_W-1:0] words [DEPTH];
    int unsigned              fill;
    logic [CAP_W-1:0]         capacity;
    stack_result_t            outstanding [$];
    int                       errors;

    function void clear();
      fill = 0;
      capacity = CAP_RESET;
      outstanding.delete();
      errors = 0;
    endfunction

    function int unsigned limit();
      return (capacity > DEPTH) ? DEPTH : capacity;
    endfunction

    function void load_capacity(logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int outstanding_count();
      return outstanding.size();
    endfunction

    function void apply_request(mode_t op, logic signed [DATA_W-1:0] value,
                                logic [POS_W-1:0] pos);
      stack_result_t r;
      int unsigned   lim;
      lim = limit();
      r.read_value = '0;
      r.status = ST_OK;
      case (op)
        MODE_PUSH: begin
          if (fill >= lim) begin
            r.status = ST_OVERFLOW;
          end else begin
            words[fill] = value;
            fill++;
          end
        end
        MODE_POP: begin
          if (fill == 0) begin
            r.status = ST_UNDERFLOW;
          end else begin
            fill--;
            r.read_value = words[fill];
          end
        end
        MODE_PEEK: begin
          if (pos == 0 || pos > fill) r.status = ST_BAD_POS;
          else r.read_value = words[fill - pos];
        end
        default: ;
      endcase
      r.is_empty = (fill == 0);
      r.is_full = (fill >= lim);
      r.entry_count = OCNT_W'(fill);
      outstanding.push_back(r);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, what);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] rd, logic [1:0] st,
                               logic emp, logic full, logic [OCNT_W-1:0] cnt);
      stack_result_t r;
      if (outstanding.size() == 0) begin
        report($sformatf("result with no request pending: rd=%0d st=%0d cnt=%0d",
                         rd, st, cnt));
        return;
      end
      r = outstanding.pop_front();
      if (rd !== r.read_value || st !== r.status || emp !== r.is_empty ||
          full !== r.is_full || cnt !== r.entry_count)
        report($sformatf({"mismatch: exp rd=%0d st=%0d empty=%0b full=%0b cnt=%0d",
                          " got rd=%0d st=%0d empty=%0b full=%0b cnt=%0d"},
                         r.read_value, r.status, r.is_empty, r.is_full,
                         r.entry_count, rd, st, emp, full, cnt));
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               mode;
  logic signed [DATA_W-1:0] push_value;
  logic [POS_W-1:0]         position;
  logic                     cfg_we;
  logic [CAP_W-1:0]         cfg_data;
  logic                     done;
  logic signed [DATA_W-1:0] read_value;
  logic [1:0]               status;
  logic                     is_empty;
  logic                     is_full;
  logic [OCNT_W-1:0]        entry_count;

  stack_mirror mirror;
  bit          filling = 1'b1;
  int unsigned phase_caps [9] = '{511, 4, 1, 0, 300, 2, 256, 17, 40};

  bounded_stack_push_pop_peek i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .push_value  (push_value),
    .position    (position),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .done        (done),
    .read_value  (read_value),
    .status      (status),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .entry_count (entry_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) mirror.check_result(read_value, status, is_empty, is_full, entry_count);
      if (cfg_we) mirror.load_capacity(cfg_data);
      if (start && !busy) mirror.apply_request(mode_t'(mode), push_value, position);
    end
  end

  task automatic issue_request(mode_t op, logic signed [DATA_W-1:0] value,
                               logic [POS_W-1:0] pos, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    mode = op;
    push_value = value;
    position = pos;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold until every pending result is back.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (mirror.outstanding_count() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Fill toward capacity, then drain toward empty, with noise mixed in.
  task automatic random_request(int gap);
    int unsigned cnt;
    int unsigned roll;
    mode_t       op;
    logic [POS_W-1:0] pos;
    cnt = mirror.fill;
    if (cnt == 0) filling = 1'b1;
    else if (cnt >= mirror.limit()) filling = 1'b0;
    roll = $urandom_range(0, 99);
    if (roll < 75) op = filling ? MODE_PUSH : MODE_POP;
    else if (roll < 85) op = filling ? MODE_POP : MODE_PUSH;
    else if (roll < 95) op = MODE_PEEK;
    else op = MODE_QUERY;
    roll = $urandom_range(0, 9);
    if (roll < 7 && cnt > 0) pos = POS_W'($urandom_range(1, cnt));
    else if (roll < 8) pos = '0;
    else if (roll < 9) pos = POS_W'(cnt + 1);
    else pos = POS_W'($urandom_range(0, 511));
    issue_request(op, $urandom, pos, gap);
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase;
    int n;
    int items;
    int gap_max;
    mirror = new;
    mirror.clear();
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_QUERY;
    push_value = '0;
    position = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty stack, default capacity
    issue_request(MODE_QUERY, 0, 0, 0);
    issue_request(MODE_POP, 0, 0, 0);
    issue_request(MODE_PEEK, 0, 0, 1);
    issue_request(MODE_PEEK, 0, 1, 0);
    issue_request(MODE_PUSH, 32'sh8000_0000, 0, 0);
    issue_request(MODE_PUSH, 32'sh7fff_ffff, 0, 2);
    issue_request(MODE_PUSH, 0, 0, 0);
    issue_request(MODE_PUSH, -1, 9'h1ff, 0);
    issue_request(MODE_PEEK, 0, 1, 0);
    issue_request(MODE_PEEK, 0, 4, 0);
    issue_request(MODE_PEEK, 0, 5, 3);
    issue_request(MODE_PEEK, 0, 256, 0);
    issue_request(MODE_PEEK, 0, 9'h1ff, 0);
    issue_request(MODE_POP, 0, 0, 0);
    issue_request(MODE_QUERY, 32'sh5555_aaaa, 9'h0aa, 0);

    // capacity equal to the count: full
    settle();
    write_capacity(3);
    issue_request(MODE_PUSH, 123, 0, 0);
    issue_request(MODE_PEEK, 0, 3, 0);

    // capacity below the count
    settle();
    write_capacity(1);
    issue_request(MODE_PUSH, 77, 0, 0);
    issue_request(MODE_POP, 0, 0, 0);
    issue_request(MODE_PEEK, 0, 2, 0);

    // zero capacity: always full, even when empty
    settle();
    write_capacity(0);
    issue_request(MODE_PUSH, 5, 0, 0);
    issue_request(MODE_POP, 0, 0, 0);
    issue_request(MODE_POP, 0, 0, 1);
    issue_request(MODE_POP, 0, 0, 0);
    issue_request(MODE_QUERY, 0, 0, 0);

    phase_caps[8] = $urandom_range(1, 64);
    gap_max = 0;
    for (phase = 0; phase < 9; phase++) begin
      settle();
      write_capacity(CAP_W'(phase_caps[phase]));
      items = (phase == 0) ? 400 : 80;
      for (n = 0; n < items; n++) begin
        if (n % 32 == 0) gap_max = $urandom_range(0, 1) ? 8 : 0;
        if ($urandom_range(0, 63) == 0) settle();
        random_request($urandom_range(0, gap_max));
      end
    end

    settle();
    if (mirror.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
